/* rtl/ritc_pkg.sv */
// ----------------------------------------------------------------------------
// ritc_pkg
// Shared types, offsets and reference tables for the image type classifier.
// ----------------------------------------------------------------------------
package ritc_pkg;

  typedef enum logic [1:0] {
    TYPE_UNKNOWN   = 2'd0,
    TYPE_HANDHELD_A = 2'd1,
    TYPE_HANDHELD_B = 2'd2,
    TYPE_HANDHELD_C = 2'd3
  } image_type_t;

  // running match flags carried with a finished image
  typedef struct packed {
    logic logo_a;
    logic sig;
    logic logo_c;
  } ritc_flags_t;

  localparam int LOGO_A_BASE     = 'h04;
  localparam int LOGO_A_LEN      = 156;
  localparam int SIG_BASE        = 'h0C;
  localparam int SIG_LEN         = 12;
  localparam int LOGO_C_BASE     = 'h104;
  localparam int LOGO_C_LEN      = 48;
  localparam int WORD0_BASE      = 'h20;
  localparam int WORD1_BASE      = 'h30;
  localparam int WORD_LEN        = 4;
  localparam int SIZE_MIN        = 192;
  localparam int SIZE_SIG_MIN    = 512;
  localparam int SIZE_LOGO_C_MIN = 'h150;
  localparam int MIB_BITS        = 20;
  localparam int MIB             = 1024 * 1024;
  localparam int SIZE_A_MAX      = 32 * 1024 * 1024;
  localparam logic [7:0] PAD_BYTE = 8'hFF;

  localparam int LOGO_A_IDX_W = $clog2(LOGO_A_LEN);
  localparam int SIG_IDX_W    = $clog2(SIG_LEN);
  localparam int LOGO_C_IDX_W = $clog2(LOGO_C_LEN);
  localparam int LANE_W       = $clog2(WORD_LEN);

  localparam logic [7:0] LOGO_A_TAB [LOGO_A_LEN] = '{
    8'h24, 8'hFF, 8'hAE, 8'h51, 8'h69, 8'h9A, 8'hA2, 8'h21, 8'h3D, 8'h84, 8'h82, 8'h0A,
    8'h84, 8'hE4, 8'h09, 8'hAD, 8'h11, 8'h24, 8'h8B, 8'h98, 8'hC0, 8'h81, 8'h7F, 8'h21,
    8'hA3, 8'h52, 8'hBE, 8'h19, 8'h93, 8'h09, 8'hCE, 8'h20, 8'h10, 8'h46, 8'h4A, 8'h4A,
    8'hF8, 8'h27, 8'h31, 8'hEC, 8'h58, 8'hC7, 8'hE8, 8'h33, 8'h82, 8'hE3, 8'hCE, 8'hBF,
    8'h85, 8'hF4, 8'hDF, 8'h94, 8'hCE, 8'h4B, 8'h09, 8'hC1, 8'h94, 8'h56, 8'h8A, 8'hC0,
    8'h13, 8'h72, 8'hA7, 8'hFC, 8'h9F, 8'h84, 8'h4D, 8'h73, 8'hA3, 8'hCA, 8'h9A, 8'h61,
    8'h58, 8'h97, 8'hA3, 8'h27, 8'hFC, 8'h03, 8'h98, 8'h76, 8'h23, 8'h1D, 8'hC7, 8'h61,
    8'h03, 8'h04, 8'hAE, 8'h56, 8'hBF, 8'h38, 8'h84, 8'h00, 8'h40, 8'hA7, 8'h0E, 8'hFD,
    8'hFF, 8'h52, 8'hFE, 8'h03, 8'h6F, 8'h95, 8'h30, 8'hF1, 8'h97, 8'hFB, 8'hC0, 8'h85,
    8'h60, 8'hD6, 8'h80, 8'h25, 8'hA9, 8'h63, 8'hBE, 8'h03, 8'h01, 8'h4E, 8'h38, 8'hE2,
    8'hF9, 8'hA2, 8'h34, 8'hFF, 8'hBB, 8'h3E, 8'h03, 8'h44, 8'h78, 8'h00, 8'h90, 8'hCB,
    8'h88, 8'h11, 8'h3A, 8'h94, 8'h65, 8'hC0, 8'h7C, 8'h63, 8'h87, 8'hF0, 8'h3C, 8'hAF,
    8'hD6, 8'h25, 8'hE4, 8'h8B, 8'h38, 8'h0A, 8'hAC, 8'h72, 8'h21, 8'hD4, 8'hF8, 8'h07
  };

  // header signature: ASCII text plus a terminating zero
  localparam logic [7:0] SIG_TAB [SIG_LEN] = '{
    8'h4E, 8'h69, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h64, 8'h6F, 8'h20, 8'h44, 8'h53, 8'h00
  };

  localparam logic [7:0] LOGO_C_TAB [LOGO_C_LEN] = '{
    8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B, 8'h03, 8'h73, 8'h00, 8'h83,
    8'h00, 8'h0C, 8'h00, 8'h0D, 8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
    8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99, 8'hBB, 8'hBB, 8'h67, 8'h63,
    8'h6E, 8'h0E, 8'hEC, 8'hCC, 8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
  };

endpackage

/* rtl/rom_image_type_classifier.sv */
// ----------------------------------------------------------------------------
// rom_image_type_classifier
// Streams a cartridge image one byte per request and reports its type code.
// ----------------------------------------------------------------------------
// Input channel: in_tdata carries one image byte per request, in file order;
// in_tlast marks the last byte of an image. Result channel: one request per
// image, out_tdata[1:0] = type (0 unknown, 1..3 handheld A/B/C).
// Throughput is one byte per cycle while the summary queue has room; the scanner
// updates its counters and table checks in the same cycle it takes a byte.
// The summary is written into the queue when the last byte is taken; the
// classifier output register loads the type code when it pops that entry.
// A two-entry summary queue sits between the scanner and the classifier, so
// the receiver may stall while later images keep streaming in; in_tready
// drops only when that queue is full, i.e. two finished images are still
// waiting behind a stalled output.
// The byte counter saturates at 2^COUNT_BITS-1.
// Reset (rst_n low, synchronous) clears the counters, sets all match flags,
// empties the queue and drops out_tvalid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rom_image_type_classifier
  import ritc_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] byte_value
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata    // [1:0] image_type, [7:2] zero
);

  localparam int FLAGS_W = $bits(ritc_flags_t);
  localparam int ENTRY_W = 2 * COUNT_BITS + 64 + FLAGS_W;

  logic                  q_full, q_not_empty, push, pop;
  logic [COUNT_BITS-1:0] f_size, f_last_idx, b_size, b_last_idx;
  logic [31:0]           f_word0, f_word1, b_word0, b_word1;
  ritc_flags_t           f_flags, b_flags;
  logic [ENTRY_W-1:0]    q_wr, q_rd;

  ritc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .q_full       (q_full),
    .push         (push),
    .sum_size     (f_size),
    .sum_last_idx (f_last_idx),
    .sum_word0    (f_word0),
    .sum_word1    (f_word1),
    .sum_flags    (f_flags)
  );

  assign q_wr = {f_size, f_last_idx, f_word0, f_word1, f_flags};

  ritc_queue #(.DATA_W(ENTRY_W), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (q_wr),
    .pop       (pop),
    .rd_data   (q_rd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign {b_size, b_last_idx, b_word0, b_word1, b_flags} = q_rd;

  ritc_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (q_not_empty),
    .pop          (pop),
    .sum_size     (b_size),
    .sum_last_idx (b_last_idx),
    .sum_word0    (b_word0),
    .sum_word1    (b_word1),
    .sum_flags    (b_flags),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

/* rtl/ritc_front.sv */
// ----------------------------------------------------------------------------
// ritc_front
// Byte scanner: counts bytes, checks the reference tables, captures the two
// offset words and the last non-pad index; pushes a summary on the last byte.
// ----------------------------------------------------------------------------
module ritc_front
  import ritc_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tlast,
  input  logic                  q_full,
  output logic                  push,
  output logic [COUNT_BITS-1:0] sum_size,
  output logic [COUNT_BITS-1:0] sum_last_idx,
  output logic [31:0]           sum_word0,
  output logic [31:0]           sum_word1,
  output ritc_flags_t           sum_flags
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] last_r, last_nxt;
  logic [31:0]           word0_r, word0_nxt;
  logic [31:0]           word1_r, word1_nxt;
  ritc_flags_t           flags_r, flags_nxt;

  logic                  acc;
  logic [COUNT_BITS-1:0] off_a, off_s, off_c, off_w0, off_w1;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [31:0]           w0_upd, w1_upd;
  logic [COUNT_BITS-1:0] last_upd;
  ritc_flags_t           flags_upd;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && !q_full;

  // offsets from each window base; a single unsigned compare tests the range
  assign off_a  = cnt_r - COUNT_BITS'(LOGO_A_BASE);
  assign off_s  = cnt_r - COUNT_BITS'(SIG_BASE);
  assign off_c  = cnt_r - COUNT_BITS'(LOGO_C_BASE);
  assign off_w0 = cnt_r - COUNT_BITS'(WORD0_BASE);
  assign off_w1 = cnt_r - COUNT_BITS'(WORD1_BASE);

  always_comb begin
    flags_upd = flags_r;
    if (off_a < COUNT_BITS'(LOGO_A_LEN) &&
        LOGO_A_TAB[off_a[LOGO_A_IDX_W-1:0]] != in_tdata) begin
      flags_upd.logo_a = 1'b0;
    end
    if (off_s < COUNT_BITS'(SIG_LEN) && SIG_TAB[off_s[SIG_IDX_W-1:0]] != in_tdata) begin
      flags_upd.sig = 1'b0;
    end
    if (off_c < COUNT_BITS'(LOGO_C_LEN) &&
        LOGO_C_TAB[off_c[LOGO_C_IDX_W-1:0]] != in_tdata) begin
      flags_upd.logo_c = 1'b0;
    end

    // little-endian byte lanes
    w0_upd = word0_r;
    if (off_w0 < COUNT_BITS'(WORD_LEN)) begin
      w0_upd[off_w0[LANE_W-1:0]*8 +: 8] = in_tdata;
    end
    w1_upd = word1_r;
    if (off_w1 < COUNT_BITS'(WORD_LEN)) begin
      w1_upd[off_w1[LANE_W-1:0]*8 +: 8] = in_tdata;
    end

    last_upd = (in_tdata != PAD_BYTE) ? cnt_r : last_r;
    cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + COUNT_BITS'(1);
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    word0_nxt = word0_r;
    word1_nxt = word1_r;
    flags_nxt = flags_r;
    if (acc) begin
      if (in_tlast) begin
        cnt_nxt   = '0;
        last_nxt  = '0;
        word0_nxt = '0;
        word1_nxt = '0;
        flags_nxt = '1;
      end else begin
        cnt_nxt   = cnt_inc;
        last_nxt  = last_upd;
        word0_nxt = w0_upd;
        word1_nxt = w1_upd;
        flags_nxt = flags_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      last_r  <= '0;
      word0_r <= '0;
      word1_r <= '0;
      flags_r <= '1;
    end else begin
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      word0_r <= word0_nxt;
      word1_r <= word1_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign push         = acc && in_tlast;
  assign sum_size     = cnt_inc;
  assign sum_last_idx = last_upd;
  assign sum_word0    = w0_upd;
  assign sum_word1    = w1_upd;
  assign sum_flags    = flags_upd;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> cnt_r == '0 && flags_r == '1)
    else $error("scanner state not cleared after last byte");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_tlast && cnt_r != CNT_MAX |=> cnt_r == $past(cnt_r) + COUNT_BITS'(1))
    else $error("byte count did not advance");

endmodule

/* rtl/ritc_queue.sv */
// ----------------------------------------------------------------------------
// ritc_queue
// Small FIFO of image summaries between scanner and classifier.
// ----------------------------------------------------------------------------
module ritc_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output logic              full,
  output logic              not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("summary queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("summary queue underflow");

endmodule

/* rtl/ritc_back.sv */
// ----------------------------------------------------------------------------
// ritc_back
// Classifier: applies the size, logo, signature and header offset checks to one
// summary and holds the type code in the output register.
// ----------------------------------------------------------------------------
module ritc_back
  import ritc_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  output logic                  pop,
  input  logic [COUNT_BITS-1:0] sum_size,
  input  logic [COUNT_BITS-1:0] sum_last_idx,
  input  logic [31:0]           sum_word0,
  input  logic [31:0]           sum_word1,
  input  ritc_flags_t           sum_flags,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata    // [1:0] image_type, [7:2] zero
);

  localparam int CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  logic          valid_r, valid_nxt;
  image_type_t   type_r, type_nxt;
  image_type_t   type_cls;

  logic [COUNT_BITS:0]  trim;
  logic [CMP_W-1:0]     size_x, w0_x, w1_x;
  logic                 size_a_win, trim_ok, offs_ok;

  always_comb begin
    // trimmed size: an all-pad image gives index 0, so trim is 1
    trim       = {1'b0, sum_last_idx} + (COUNT_BITS+1)'(1);
    size_a_win = sum_size >= COUNT_BITS'(MIB) && sum_size <= COUNT_BITS'(SIZE_A_MAX);
    trim_ok    = ((trim & (trim - (COUNT_BITS+1)'(1))) == '0) ||
                 (trim[MIB_BITS-1:0] == '0);
    size_x     = CMP_W'(sum_size);
    w0_x       = CMP_W'(sum_word0);
    w1_x       = CMP_W'(sum_word1);
    offs_ok    = w0_x < size_x && w1_x < size_x &&
                 sum_word0[1:0] == 2'b00 && sum_word1[1:0] == 2'b00;

    priority if (sum_size < COUNT_BITS'(SIZE_MIN)) begin
      type_cls = TYPE_UNKNOWN;
    end else if (sum_flags.logo_a || (size_a_win && trim_ok)) begin
      type_cls = TYPE_HANDHELD_A;
    end else if (sum_size >= COUNT_BITS'(SIZE_SIG_MIN) && (sum_flags.sig || offs_ok)) begin
      type_cls = TYPE_HANDHELD_B;
    end else if (sum_size >= COUNT_BITS'(SIZE_LOGO_C_MIN) && sum_flags.logo_c) begin
      type_cls = TYPE_HANDHELD_C;
    end else begin
      type_cls = TYPE_UNKNOWN;
    end
  end

  assign pop = q_not_empty && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    type_nxt  = type_r;
    if (pop) begin
      valid_nxt = 1'b1;
      type_nxt  = type_cls;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'b0, type_r};

endmodule
